>>> design/serial_setpoint_p_regulator_defines.svh
// Assertion macros for the serial setpoint regulator.
// Included by the top level; no other dependencies.
`ifndef SERIAL_SETPOINT_P_REGULATOR_DEFINES_SVH
`define SERIAL_SETPOINT_P_REGULATOR_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define SSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssp: implication check failed");

// next-cycle implication, ignored while reset is asserted
`define SSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssp: next-cycle check failed");

`endif

>>> design/ssp_pkg.sv
// Shared types and constants for the serial setpoint regulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssp_pkg;

    localparam int DUTY_BITS_DEF = 10;
    localparam int FRAME_LENGTH  = 4;
    localparam int TARGET_BITS   = 15;
    localparam int ADC_BITS      = 10;
    localparam int GAIN_BITS     = 16;
    localparam int BLINK_BITS    = 16;
    localparam int ACKT_BITS     = 4;
    localparam int IN_TDATA_W    = 24;
    localparam int PADDR_W       = 5;

    // x/5 == (x * FIFTH_RECIP) >> FIFTH_SHIFT, exact for x < 131072
    localparam logic [15:0] FIFTH_RECIP = 16'd52429;
    localparam int          FIFTH_SHIFT = 18;

    typedef logic [1:0] t_op;
    localparam t_op OP_BYTE   = 2'd0;
    localparam t_op OP_SAMPLE = 2'd1;
    localparam t_op OP_MS     = 2'd2;
    localparam t_op OP_IND    = 2'd3;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ADDR  = 3'd0;
    localparam t_reg_idx REG_GAIN  = 3'd1;
    localparam t_reg_idx REG_SLOW  = 3'd2;
    localparam t_reg_idx REG_FAST  = 3'd3;
    localparam t_reg_idx REG_ACKT  = 3'd4;

    localparam logic [7:0]            RST_ADDR = 8'd1;
    localparam logic [GAIN_BITS-1:0]  RST_GAIN = 16'd1311;
    localparam logic [BLINK_BITS-1:0] RST_SLOW = 16'd500;
    localparam logic [BLINK_BITS-1:0] RST_FAST = 16'd100;
    localparam logic [ACKT_BITS-1:0]  RST_ACKT = 4'd10;

    typedef struct packed {
        logic [7:0]            dev_addr;
        logic [GAIN_BITS-1:0]  gain;
        logic [BLINK_BITS-1:0] slow_ms;
        logic [BLINK_BITS-1:0] fast_ms;
        logic [ACKT_BITS-1:0]  ack_ticks;
    } t_cfg;

    // one event leaving the input register this cycle
    typedef struct packed {
        logic fire;
        t_op  op;
    } t_evt;

endpackage

`default_nettype wire

>>> design/serial_setpoint_p_regulator.sv
// Serial setpoint proportional PWM regulator: input stage, register file,
// result register. Depends on ssp_pkg, ssp_frame, ssp_duty, ssp_led and the defines header.
//
// Usage:
//  - Slave stream: one event word per handshake. tuser carries the event kind
//    (serial byte, converter sample, millisecond tick, indicator tick); tdata
//    carries the received byte and the converter sample.
//  - Master stream: one result word per event: duty, setpoint in counts, both
//    LED levels, frame-complete flag and in-band flag.
//  - APB port: five registers at byte addresses 0, 4, 8, 12, 16. The user must see that
//    they are written only while the stream is idle; the block does not enforce it.
//    pready is tied high; reads return the register.
//  - Path: an accepted word passes two registers, input register then result register.
//  - Throughput: one word per cycle while the master side takes each result; the
//    update between the input register and the result register is combinational.
//  - Stall: while the result is not taken the input register keeps one more
//    word; s_axis_tready falls only when both registers are full.
//  - Reset (synchronous, active low) empties both registers, clears duty,
//    setpoint, frame position, timers and LEDs, and loads register defaults.
`default_nettype none
`include "serial_setpoint_p_regulator_defines.svh"

module serial_setpoint_p_regulator #(
    parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] rx_byte, [17:8] adc_sample, [23:18] zero
    input  wire logic [ssp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [DUTY_BITS-1:0] pwm_duty, then setpoint_now(15), ack_led, status_led,
    // frame_accepted, in_band, zero fill
    output logic [((DUTY_BITS+ssp_pkg::TARGET_BITS+4+7)/8)*8-1:0] m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ssp_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import ssp_pkg::*;

    localparam int OUT_W  = DUTY_BITS + TARGET_BITS + 4;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    t_cfg                   r_cfg;
    t_reg_idx               w_ridx;
    logic                   w_wr;

    logic                   r_in_valid;
    t_op                    r_op;
    logic [7:0]             r_rx;
    logic [ADC_BITS-1:0]    r_adc;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;

    logic                   w_advance;
    logic                   w_fire;
    t_evt                   w_evt;

    logic [TARGET_BITS-1:0] w_target;
    logic [TARGET_BITS-1:0] w_target_next;
    logic                   w_seen;
    logic                   w_accepted;
    logic [DUTY_BITS-1:0]   w_duty_next;
    logic                   w_in_band;
    logic                   w_ack_next;
    logic                   w_status_next;

    // configuration registers
    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr  <= RST_ADDR;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.slow_ms   <= RST_SLOW;
            r_cfg.fast_ms   <= RST_FAST;
            r_cfg.ack_ticks <= RST_ACKT;
        end else if (w_wr) begin
            case (w_ridx)
                REG_ADDR: r_cfg.dev_addr  <= pwdata[7:0];
                REG_GAIN: r_cfg.gain      <= pwdata[GAIN_BITS-1:0];
                REG_SLOW: r_cfg.slow_ms   <= pwdata[BLINK_BITS-1:0];
                REG_FAST: r_cfg.fast_ms   <= pwdata[BLINK_BITS-1:0];
                REG_ACKT: r_cfg.ack_ticks <= pwdata[ACKT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            REG_ADDR: prdata = 32'(r_cfg.dev_addr);
            REG_GAIN: prdata = 32'(r_cfg.gain);
            REG_SLOW: prdata = 32'(r_cfg.slow_ms);
            REG_FAST: prdata = 32'(r_cfg.fast_ms);
            REG_ACKT: prdata = 32'(r_cfg.ack_ticks);
            default:  prdata = 32'd0;
        endcase
    end

    // two-entry pipeline: input register feeds the result register
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_fire        = r_in_valid && w_advance;
    assign w_evt.fire    = w_fire;
    assign w_evt.op      = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tuser;
            r_rx  <= s_axis_tdata[7:0];
            r_adc <= s_axis_tdata[17:8];
        end
        if (w_fire) begin
            r_out <= {w_in_band, w_accepted, w_status_next, w_ack_next,
                      w_target_next, w_duty_next};
        end
    end

    ssp_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (w_evt),
        .i_byte        (r_rx),
        .i_cfg         (r_cfg),
        .o_target      (w_target),
        .o_target_next (w_target_next),
        .o_seen        (w_seen),
        .o_accepted    (w_accepted)
    );

    ssp_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .i_sample    (r_adc),
        .i_target    (w_target),
        .i_cfg       (r_cfg),
        .o_duty_next (w_duty_next),
        .o_in_band   (w_in_band)
    );

    ssp_led u_led (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (w_evt),
        .i_cfg         (r_cfg),
        .i_seen        (w_seen),
        .i_accepted    (w_accepted),
        .i_in_band     (w_in_band),
        .o_ack_next    (w_ack_next),
        .o_status_next (w_status_next)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'(r_out);

    // a completed frame always lights the acknowledge LED in the same word
    `SSP_ASSERT_IMP(a_ack_on_frame, i_clk, i_rst_n, r_out_valid && r_out[OUT_W-2], r_out[OUT_W-4])
    // a word is either a frame byte or a sample, never both
    `SSP_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, r_out_valid, !(r_out[OUT_W-1] && r_out[OUT_W-2]))
    // a stalled input word is not dropped
    `SSP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)

endmodule

`default_nettype wire

>>> design/ssp_frame.sv
// Frame assembler: collects address/high/low/check bytes and latches the target.
// Depends on ssp_pkg.
`default_nettype none

module ssp_frame (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ssp_pkg::t_evt                  i_evt,
    input  wire logic [7:0]                     i_byte,
    input  wire ssp_pkg::t_cfg                  i_cfg,
    output logic [ssp_pkg::TARGET_BITS-1:0]     o_target,
    output logic [ssp_pkg::TARGET_BITS-1:0]     o_target_next,
    output logic                                o_seen,
    output logic                                o_accepted
);
    import ssp_pkg::*;

    localparam int        NBYTES   = FRAME_LENGTH - 1;
    localparam logic [1:0] LAST_POS = 2'(FRAME_LENGTH - 1);

    logic [1:0]             r_pos;
    logic [7:0]             r_bytes [NBYTES];
    logic [TARGET_BITS-1:0] r_target;
    logic                   r_seen;

    logic                   w_byte_evt;
    logic [15:0]            w_v;
    logic [25:0]            w_x;
    logic [16:0]            w_y;
    logic [32:0]            w_qprod;
    logic [TARGET_BITS-1:0] w_q;

    assign w_byte_evt = i_evt.fire && (i_evt.op == OP_BYTE);

    // v*1023/2560 = ((v*1024 - v) >> 9) / 5
    assign w_v     = {r_bytes[1], r_bytes[2]};
    assign w_x     = {w_v, 10'd0} - {10'd0, w_v};
    assign w_y     = w_x[25:9];
    assign w_qprod = 33'(w_y) * 33'(FIFTH_RECIP);
    assign w_q     = w_qprod[32:FIFTH_SHIFT];

    assign o_accepted    = w_byte_evt && (r_pos == LAST_POS) && (r_bytes[0] == i_cfg.dev_addr);
    assign o_target_next = o_accepted ? w_q : r_target;
    assign o_target      = r_target;
    assign o_seen        = r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_target <= '0;
            r_seen   <= 1'b0;
        end else if (w_byte_evt) begin
            if (r_pos == LAST_POS) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
            if (o_accepted) begin
                r_target <= w_q;
                r_seen   <= 1'b1;
            end
        end
    end

    // byte store, written before it is read within each frame
    always_ff @(posedge i_clk) begin
        if (w_byte_evt && (r_pos != LAST_POS)) begin
            r_bytes[r_pos] <= i_byte;
        end
    end

endmodule

`default_nettype wire

>>> design/ssp_duty.sv
// Proportional duty update and band check on each converter sample.
// Depends on ssp_pkg.
`default_nettype none

module ssp_duty #(
    parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ssp_pkg::t_evt                  i_evt,
    input  wire logic [ssp_pkg::ADC_BITS-1:0]   i_sample,
    input  wire logic [ssp_pkg::TARGET_BITS-1:0] i_target,
    input  wire ssp_pkg::t_cfg                  i_cfg,
    output logic [DUTY_BITS-1:0]                o_duty_next,
    output logic                                o_in_band
);
    import ssp_pkg::*;

    localparam int STEP_W = 16;
    localparam int SUM_W  = ((DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W) + 1;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    logic [DUTY_BITS-1:0]   r_duty;
    logic [DUTY_BITS-1:0]   n_duty;

    logic                   w_sample_evt;
    logic [TARGET_BITS-1:0] w_s;
    logic                   w_up;
    logic [TARGET_BITS-1:0] w_err;
    logic [30:0]            w_prod;
    logic [31:0]            w_prod_r;
    logic [STEP_W-1:0]      w_step;
    logic [SUM_W-1:0]       w_sum;
    logic [SUM_W-1:0]       w_dif;
    logic [31:0]            w_fprod;
    logic [12:0]            w_fifth;
    logic [15:0]            w_lo;
    logic [15:0]            w_hi;

    assign w_sample_evt = i_evt.fire && (i_evt.op == OP_SAMPLE);
    assign w_s          = TARGET_BITS'(i_sample);
    assign w_up         = i_target > w_s;
    assign w_err        = w_up ? (i_target - w_s) : (w_s - i_target);
    assign w_prod       = 31'(i_cfg.gain) * 31'(w_err);
    // increase floors, decrease rounds up
    assign w_prod_r     = {1'b0, w_prod} + (w_up ? 32'd0 : 32'h0000_FFFF);
    assign w_step       = w_prod_r[31:16];
    assign w_sum        = SUM_W'(r_duty) + SUM_W'(w_step);
    assign w_dif        = SUM_W'(r_duty) - SUM_W'(w_step);

    always_comb begin
        if (w_up) begin
            n_duty = (w_sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : w_sum[DUTY_BITS-1:0];
        end else begin
            n_duty = (SUM_W'(w_step) > SUM_W'(r_duty)) ? '0 : w_dif[DUTY_BITS-1:0];
        end
    end

    assign w_fprod   = 32'(i_target) * 32'(FIFTH_RECIP);
    assign w_fifth   = w_fprod[30:FIFTH_SHIFT];
    assign w_lo      = 16'(i_target) - 16'(w_fifth);
    assign w_hi      = 16'(i_target) + 16'(w_fifth);
    assign o_in_band = w_sample_evt && (16'(i_sample) >= w_lo) && (16'(i_sample) <= w_hi);

    assign o_duty_next = w_sample_evt ? n_duty : r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= '0;
        end else if (w_sample_evt) begin
            r_duty <= n_duty;
        end
    end

endmodule

`default_nettype wire

>>> design/ssp_led.sv
// Status blink timer and acknowledge LED timeout.
// Depends on ssp_pkg.
`default_nettype none

module ssp_led (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ssp_pkg::t_evt i_evt,
    input  wire ssp_pkg::t_cfg i_cfg,
    input  wire logic          i_seen,
    input  wire logic          i_accepted,
    input  wire logic          i_in_band,
    output logic               o_ack_next,
    output logic               o_status_next
);
    import ssp_pkg::*;

    logic [BLINK_BITS-1:0] r_blink;
    logic [BLINK_BITS-1:0] n_blink;
    logic                  r_status;
    logic                  n_status;
    logic                  r_ack;
    logic                  n_ack;
    logic [ACKT_BITS-1:0]  r_ack_cnt;
    logic [ACKT_BITS-1:0]  n_ack_cnt;

    logic [BLINK_BITS-1:0] w_interval;
    logic [ACKT_BITS-1:0]  w_ack_inc;

    assign w_interval = i_in_band ? i_cfg.slow_ms : i_cfg.fast_ms;
    assign w_ack_inc  = r_ack_cnt + ACKT_BITS'(1);

    always_comb begin
        n_blink   = r_blink;
        n_status  = r_status;
        n_ack     = r_ack;
        n_ack_cnt = r_ack_cnt;
        if (i_evt.fire) begin
            case (i_evt.op)
                OP_BYTE: begin
                    // retrigger relights but keeps the count
                    if (i_accepted) begin
                        n_ack = 1'b1;
                    end
                end
                OP_SAMPLE: begin
                    if (i_seen && (r_blink >= w_interval)) begin
                        n_status = !r_status;
                        n_blink  = '0;
                    end
                end
                OP_MS: begin
                    n_blink = r_blink + BLINK_BITS'(1);
                end
                OP_IND: begin
                    if (r_ack) begin
                        if (w_ack_inc == i_cfg.ack_ticks) begin
                            n_ack     = 1'b0;
                            n_ack_cnt = '0;
                        end else begin
                            n_ack_cnt = w_ack_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ack_next    = n_ack;
    assign o_status_next = n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink   <= '0;
            r_status  <= 1'b0;
            r_ack     <= 1'b0;
            r_ack_cnt <= '0;
        end else begin
            r_blink   <= n_blink;
            r_status  <= n_status;
            r_ack     <= n_ack;
            r_ack_cnt <= n_ack_cnt;
        end
    end

endmodule

`default_nettype wire
